FILE: rtl/dc_motor_euler_step_unit_assert.svh
// ----------------------------------------------------------------------------
// DC motor Euler step unit: assertion macros
// Concurrent checks clocked by clk_i; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DC_MOTOR_EULER_STEP_UNIT_ASSERT_SVH
`define DC_MOTOR_EULER_STEP_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define DCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// checked on every edge, reset included
`define DCM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define DCM_ASSERT(lbl, prop)
`define DCM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/dcm_pkg.sv
// ----------------------------------------------------------------------------
// DC motor Euler step: shared package
// Word format, register map, sequencer states and saturating helpers.
// ----------------------------------------------------------------------------
package dcm_pkg;

  localparam int WORD_W      = 32;  // signed Q16.16 word
  localparam int FRAC_W      = 16;
  localparam int CFG_W       = 31;  // configuration registers, unsigned
  localparam int DIGIT_W     = 8;   // multiplier digit per cycle
  localparam int DIGIT_STEPS = WORD_W / DIGIT_W;
  localparam int STEP_CNT_W  = $clog2(DIGIT_STEPS);
  localparam int ACC_W       = WORD_W + DIGIT_W + 2;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] RST_STEP_SIZE   = 31'd3277;
  localparam logic [CFG_W-1:0] RST_INV_L       = 31'd1310720;
  localparam logic [CFG_W-1:0] RST_INV_J       = 31'd131072;
  localparam logic [CFG_W-1:0] RST_KV          = 31'd81920;
  localparam logic [CFG_W-1:0] RST_KT          = 31'd65536;
  localparam logic [CFG_W-1:0] RST_FRICTION    = 31'd66;

  typedef enum logic [2:0] {
    REG_STEP_SIZE,
    REG_INV_INDUCTANCE,
    REG_INV_INERTIA,
    REG_BACK_EMF,
    REG_TORQUE,
    REG_FRICTION
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_SUBT,
    ST_M3,
    ST_M4,
    ST_OUT
  } dcm_state_e;

  typedef struct packed {
    logic [CFG_W-1:0] step_size;
    logic [CFG_W-1:0] inv_inductance;
    logic [CFG_W-1:0] inv_inertia;
    logic [CFG_W-1:0] back_emf_constant;
    logic [CFG_W-1:0] torque_constant;
    logic [CFG_W-1:0] friction_coefficient;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, result valid
    logic sat;   // product clipped
  } mul_stat_t;

  function automatic logic signed [WORD_W:0] ext_add(input logic signed [WORD_W-1:0] a,
                                                     input logic signed [WORD_W-1:0] b);
    return {a[WORD_W-1], a} + {b[WORD_W-1], b};
  endfunction

  function automatic logic signed [WORD_W:0] ext_sub(input logic signed [WORD_W-1:0] a,
                                                     input logic signed [WORD_W-1:0] b);
    return {a[WORD_W-1], a} - {b[WORD_W-1], b};
  endfunction

  function automatic logic word_ovf(input logic signed [WORD_W:0] x);
    return x[WORD_W] ^ x[WORD_W-1];
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W:0] x);
    logic signed [WORD_W-1:0] res;
    if (x[WORD_W] != x[WORD_W-1]) begin
      res = x[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      res = x[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/dcm_cfg_regs.sv
// ----------------------------------------------------------------------------
// DC motor Euler step: configuration registers
// APB-style register file holding the six model coefficients.
// ----------------------------------------------------------------------------
module dcm_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [dcm_pkg::PDATA_W-1:0]  pwdata,
  output logic [dcm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output dcm_pkg::cfg_t                cfg_o
);

  dcm_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        dcm_pkg::REG_STEP_SIZE:      cfg_d.step_size            = pwdata[dcm_pkg::CFG_W-1:0];
        dcm_pkg::REG_INV_INDUCTANCE: cfg_d.inv_inductance       = pwdata[dcm_pkg::CFG_W-1:0];
        dcm_pkg::REG_INV_INERTIA:    cfg_d.inv_inertia          = pwdata[dcm_pkg::CFG_W-1:0];
        dcm_pkg::REG_BACK_EMF:       cfg_d.back_emf_constant    = pwdata[dcm_pkg::CFG_W-1:0];
        dcm_pkg::REG_TORQUE:         cfg_d.torque_constant      = pwdata[dcm_pkg::CFG_W-1:0];
        dcm_pkg::REG_FRICTION:       cfg_d.friction_coefficient = pwdata[dcm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dcm_pkg::REG_STEP_SIZE:      prdata = {1'b0, cfg_q.step_size};
      dcm_pkg::REG_INV_INDUCTANCE: prdata = {1'b0, cfg_q.inv_inductance};
      dcm_pkg::REG_INV_INERTIA:    prdata = {1'b0, cfg_q.inv_inertia};
      dcm_pkg::REG_BACK_EMF:       prdata = {1'b0, cfg_q.back_emf_constant};
      dcm_pkg::REG_TORQUE:         prdata = {1'b0, cfg_q.torque_constant};
      dcm_pkg::REG_FRICTION:       prdata = {1'b0, cfg_q.friction_coefficient};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size            <= dcm_pkg::RST_STEP_SIZE;
      cfg_q.inv_inductance       <= dcm_pkg::RST_INV_L;
      cfg_q.inv_inertia          <= dcm_pkg::RST_INV_J;
      cfg_q.back_emf_constant    <= dcm_pkg::RST_KV;
      cfg_q.torque_constant      <= dcm_pkg::RST_KT;
      cfg_q.friction_coefficient <= dcm_pkg::RST_FRICTION;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/dcm_ser_mul.sv
// ----------------------------------------------------------------------------
// DC motor Euler step: digit-serial fixed-point multiplier
// Signed word times signed word, one 8-bit digit of b per cycle, LSB first.
// Result is the product shifted right by FRAC_W (floor), clipped to a word.
// ----------------------------------------------------------------------------
`include "dc_motor_euler_step_unit_assert.svh"

module dcm_ser_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [dcm_pkg::WORD_W-1:0]   a_i,
  input  logic signed [dcm_pkg::WORD_W-1:0]   b_i,
  output dcm_pkg::mul_stat_t                  stat_o,
  output logic signed [dcm_pkg::WORD_W-1:0]   result_o
);

  localparam int W  = dcm_pkg::WORD_W;
  localparam int DW = dcm_pkg::DIGIT_W;
  localparam int AW = dcm_pkg::ACC_W;
  localparam int CW = dcm_pkg::STEP_CNT_W;
  localparam int PW = W + DW + 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [W-1:0]  a_q;
  logic [W-1:0]         b_q;
  logic signed [AW-1:0] acc_q;
  logic [W-1:0]         lo_q;

  logic                 last;
  logic signed [DW:0]   dig;
  logic signed [W+DW:0] pp;
  logic signed [AW-1:0] sum;
  logic [2*W-1:0]       prod;
  logic                 ovf;

  assign last = (cnt_q == CW'(dcm_pkg::DIGIT_STEPS - 1));
  // top digit carries the sign weight of b
  assign dig  = $signed({last & b_q[DW-1], b_q[DW-1:0]});
  assign pp   = PW'(a_q) * PW'(dig);
  assign sum  = acc_q + AW'(pp);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && last;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= sum >>> DW;
      lo_q  <= {sum[DW-1:0], lo_q[W-1:DW]};
      b_q   <= b_q >> DW;
    end
  end

  // acc holds the high word of the exact product once all digits are in
  assign prod = {acc_q[W-1:0], lo_q};
  assign ovf  = !((&acc_q[AW-1:dcm_pkg::FRAC_W-1]) || !(|acc_q[AW-1:dcm_pkg::FRAC_W-1]));

  always_comb begin
    if (ovf) begin
      result_o = acc_q[AW-1] ? dcm_pkg::WORD_MIN : dcm_pkg::WORD_MAX;
    end else begin
      result_o = prod[dcm_pkg::FRAC_W +: W];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.sat  = ovf;

  `DCM_ASSERT(a_start_when_free, start_i |-> !busy_q)
  `DCM_ASSERT(a_last_digit_done, busy_q && last && !start_i |=> done_q && !busy_q)
  `DCM_ASSERT_ALWAYS(a_done_not_busy, !(done_q && busy_q))

endmodule

FILE: rtl/dc_motor_euler_step_unit.sv
// ----------------------------------------------------------------------------
// DC motor Euler step unit
// Brushed DC motor plant model, one forward-Euler step per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer (voltage, winding resistance, load torque) advances the
// motor current and rotor speed by one step and yields one output transfer
// with the new state and a flag set if any product, sum or state value was
// clipped. All data is signed Q16.16; products are floor-truncated. An item
// is accepted, then two digit-serial multipliers (one for the current path,
// one for the speed path) run four rounds, 8 bits of the multiplier word per
// cycle, with the load-torque subtract between the second and third round;
// last the result is written to the output register, which waits while the
// output is stalled. One item is in work at a time; a finished result waits
// in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`include "dc_motor_euler_step_unit_assert.svh"

module dc_motor_euler_step_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dcm_pkg::PADDR_W-1:0]         paddr,
  input  logic [dcm_pkg::PDATA_W-1:0]         pwdata,
  output logic [dcm_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [dcm_pkg::WORD_W-1:0]   applied_voltage_i,
  input  logic [dcm_pkg::CFG_W-1:0]           winding_resistance_i,
  input  logic signed [dcm_pkg::WORD_W-1:0]   load_torque_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dcm_pkg::WORD_W-1:0]   motor_current_o,
  output logic signed [dcm_pkg::WORD_W-1:0]   angular_speed_o,
  output logic                                saturated_o
);

  localparam int W = dcm_pkg::WORD_W;

  dcm_pkg::cfg_t       cfg;
  dcm_pkg::dcm_state_e state_q, state_d;

  logic signed [W-1:0] volt_q, volt_d;
  logic signed [W-1:0] res_q, res_d;
  logic signed [W-1:0] tload_q, tload_d;
  logic signed [W-1:0] acc_a_q, acc_a_d;
  logic signed [W-1:0] acc_b_q, acc_b_d;
  logic signed [W-1:0] cur_q, cur_d;
  logic signed [W-1:0] spd_q, spd_d;
  logic                sat_q, sat_d;
  logic signed [W-1:0] out_cur_q, out_cur_d;
  logic signed [W-1:0] out_spd_q, out_spd_d;
  logic                out_sat_q, out_sat_d;
  logic                out_valid_q, out_valid_d;

  logic                mul_start;
  logic signed [W-1:0] ma_a, ma_b, mb_a, mb_b;
  logic signed [W-1:0] res_a, res_b;
  dcm_pkg::mul_stat_t  stat_a, stat_b;

  logic                in_xfer;
  logic                out_free;
  logic                out_wr;

  dcm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // current path
  dcm_ser_mul u_mul_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (ma_a),
    .b_i      (ma_b),
    .stat_o   (stat_a),
    .result_o (res_a)
  );

  // speed path
  dcm_ser_mul u_mul_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mb_a),
    .b_i      (mb_b),
    .stat_o   (stat_b),
    .result_o (res_b)
  );

  assign in_stall_o = (state_q != dcm_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_wr     = (state_q == dcm_pkg::ST_OUT) && out_free;

  always_comb begin
    logic signed [W:0] da;
    logic signed [W:0] db;

    state_d     = state_q;
    volt_d      = volt_q;
    res_d       = res_q;
    tload_d     = tload_q;
    acc_a_d     = acc_a_q;
    acc_b_d     = acc_b_q;
    cur_d       = cur_q;
    spd_d       = spd_q;
    sat_d       = sat_q;
    out_cur_d   = out_cur_q;
    out_spd_d   = out_spd_q;
    out_sat_d   = out_sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_start   = 1'b0;
    ma_a        = '0;
    ma_b        = '0;
    mb_a        = '0;
    mb_b        = '0;
    da          = '0;
    db          = '0;

    case (state_q)
      dcm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          volt_d    = applied_voltage_i;
          res_d     = {1'b0, winding_resistance_i};
          tload_d   = load_torque_i;
          sat_d     = 1'b0;
          mul_start = 1'b1;
          ma_a      = {1'b0, cfg.back_emf_constant};
          ma_b      = spd_q;
          mb_a      = {1'b0, cfg.torque_constant};
          mb_b      = cur_q;
          state_d   = dcm_pkg::ST_M1;
        end
      end
      dcm_pkg::ST_M1: begin
        if (stat_a.done) begin
          da        = dcm_pkg::ext_sub(volt_q, res_a);
          acc_a_d   = dcm_pkg::sat_word(da);
          acc_b_d   = res_b;
          sat_d     = sat_q | stat_a.sat | stat_b.sat | dcm_pkg::word_ovf(da);
          mul_start = 1'b1;
          ma_a      = res_q;
          ma_b      = cur_q;
          mb_a      = {1'b0, cfg.friction_coefficient};
          mb_b      = spd_q;
          state_d   = dcm_pkg::ST_M2;
        end
      end
      dcm_pkg::ST_M2: begin
        if (stat_a.done) begin
          da      = dcm_pkg::ext_sub(acc_a_q, res_a);
          db      = dcm_pkg::ext_sub(acc_b_q, res_b);
          acc_a_d = dcm_pkg::sat_word(da);
          acc_b_d = dcm_pkg::sat_word(db);
          sat_d   = sat_q | stat_a.sat | stat_b.sat | dcm_pkg::word_ovf(da)
                    | dcm_pkg::word_ovf(db);
          state_d = dcm_pkg::ST_SUBT;
        end
      end
      dcm_pkg::ST_SUBT: begin
        db        = dcm_pkg::ext_sub(acc_b_q, tload_q);
        acc_b_d   = dcm_pkg::sat_word(db);
        sat_d     = sat_q | dcm_pkg::word_ovf(db);
        mul_start = 1'b1;
        ma_a      = acc_a_q;
        ma_b      = {1'b0, cfg.inv_inductance};
        mb_a      = acc_b_d;
        mb_b      = {1'b0, cfg.inv_inertia};
        state_d   = dcm_pkg::ST_M3;
      end
      dcm_pkg::ST_M3: begin
        // derivatives times step size
        if (stat_a.done) begin
          sat_d     = sat_q | stat_a.sat | stat_b.sat;
          mul_start = 1'b1;
          ma_a      = res_a;
          ma_b      = {1'b0, cfg.step_size};
          mb_a      = res_b;
          mb_b      = {1'b0, cfg.step_size};
          state_d   = dcm_pkg::ST_M4;
        end
      end
      dcm_pkg::ST_M4: begin
        if (stat_a.done) begin
          da      = dcm_pkg::ext_add(cur_q, res_a);
          db      = dcm_pkg::ext_add(spd_q, res_b);
          acc_a_d = dcm_pkg::sat_word(da);
          acc_b_d = dcm_pkg::sat_word(db);
          sat_d   = sat_q | stat_a.sat | stat_b.sat | dcm_pkg::word_ovf(da)
                    | dcm_pkg::word_ovf(db);
          state_d = dcm_pkg::ST_OUT;
        end
      end
      dcm_pkg::ST_OUT: begin
        if (out_free) begin
          cur_d       = acc_a_q;
          spd_d       = acc_b_q;
          out_cur_d   = acc_a_q;
          out_spd_d   = acc_b_q;
          out_sat_d   = sat_q;
          out_valid_d = 1'b1;
          state_d     = dcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcm_pkg::ST_IDLE;
      cur_q       <= '0;
      spd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      spd_q       <= spd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    volt_q    <= volt_d;
    res_q     <= res_d;
    tload_q   <= tload_d;
    acc_a_q   <= acc_a_d;
    acc_b_q   <= acc_b_d;
    sat_q     <= sat_d;
    out_cur_q <= out_cur_d;
    out_spd_q <= out_spd_d;
    out_sat_q <= out_sat_d;
  end

  assign out_valid_o     = out_valid_q;
  assign motor_current_o = out_cur_q;
  assign angular_speed_o = out_spd_q;
  assign saturated_o     = out_sat_q;

  `DCM_ASSERT(a_accept_starts_mul, in_xfer |=> stat_a.busy && stat_b.busy)
  `DCM_ASSERT_ALWAYS(a_mul_lockstep, stat_a.busy == stat_b.busy && stat_a.done == stat_b.done)
  `DCM_ASSERT(a_out_matches_state, out_wr |=> out_valid_o && motor_current_o == cur_q && angular_speed_o == spd_q)

endmodule
